// ===== design/gda_pkg.sv =====
// Shared types, constants and calendar helpers for the date arithmetic unit.
package gda_pkg;

   localparam logic [1:0] OP_NEXT = 2'd0;
   localparam logic [1:0] OP_ADD  = 2'd1;
   localparam logic [1:0] OP_DOY  = 2'd2;
   localparam logic [1:0] OP_CMP  = 2'd3;

   // The leap pattern repeats every 400 years, which hold this many days.
   localparam int LEAP_SPAN   = 400;
   localparam int CYCLE_DAYS  = 146097;
   localparam int CYCLE_YEARS = 400;

   typedef struct packed {
      logic load;     // capture a new item
      logic load_r;   // take the year remainder from the reduction unit
      logic step;     // run one step of the shared adder
   } gda_ctl_type;

   typedef struct packed {
      logic exec_done;
   } gda_sts_type;

   // Leap test from the year reduced modulo 400.
   function automatic logic is_leap(input logic [8:0] r);
      logic cent;
      cent = (r == 9'd100) || (r == 9'd200) || (r == 9'd300);
      return ((r[1:0] == 2'b00) && !cent) || (r == 9'd0);
   endfunction

   // Month 0 and months above twelve count as 31-day months.
   function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
      logic [4:0] len;
      case (m) inside
         4'd2: begin
            len = leap ? 5'd29 : 5'd28;
         end
         4'd4, 4'd6, 4'd9, 4'd11: begin
            len = 5'd30;
         end
         default: begin
            len = 5'd31;
         end
      endcase
      return len;
   endfunction

endpackage

// ===== design/gregorian_date_arithmetic.sv =====
// Top level of the Gregorian date arithmetic unit: sequencer and result strobe.
//
// An item is taken when start is high and busy is low; busy then stays high until the
// result beat, which is on the rsp_ ports for one cycle under rsp_valid and cannot be
// held off. Every item first reduces its year modulo 400 with a reciprocal multiply
// (a multiply phase, then a subtract phase), then runs a sequence of steps on one shared
// add/subtract unit, one month per step, and ends with one result cycle. Next day and
// compare take a single step, day of year sums the lengths of the months before the given
// month, and add days walks month by month until the day fits; with wide counts whole
// 400-year spans are skipped one per cycle. The next item can be taken in the cycle
// right after the result beat.
module gregorian_date_arithmetic import gda_pkg::*; #(
   parameter int YEAR_BITS  = 16,
   parameter int COUNT_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [1:0]            req_opcode,
   input  logic [4:0]            req_day,
   input  logic [3:0]            req_month,
   input  logic [YEAR_BITS-1:0]  req_year,
   input  logic [4:0]            req_other_day,
   input  logic [3:0]            req_other_month,
   input  logic [YEAR_BITS-1:0]  req_other_year,
   input  logic [COUNT_BITS-1:0] req_add_count,
   output logic                  rsp_valid,
   output logic [4:0]            rsp_out_day,
   output logic [3:0]            rsp_out_month,
   output logic [YEAR_BITS-1:0]  rsp_out_year,
   output logic [8:0]            rsp_day_of_year,
   output logic                  rsp_is_less,
   output logic                  rsp_is_equal
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_REM  = 2'd1;
   localparam logic [1:0] S_EXEC = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   logic [1:0]  state_ff, state_in;
   gda_ctl_type ctl;
   gda_sts_type sts;
   logic        rem_done;
   logic [8:0]  year_rem;

   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               ctl.load = 1'b1;
               state_in = S_REM;
            end
         end
         S_REM: begin
            if (rem_done) begin
               ctl.load_r = 1'b1;
               state_in   = S_EXEC;
            end
         end
         S_EXEC: begin
            ctl.step = 1'b1;
            if (sts.exec_done) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_DONE);

   gda_rem400 #(
      .YEAR_BITS (YEAR_BITS)
   ) u_rem400 (
      .clock (clock),
      .reset (reset),
      .load  (ctl.load),
      .year  (req_year),
      .done  (rem_done),
      .rem   (year_rem)
   );

   gda_datapath #(
      .YEAR_BITS  (YEAR_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_datapath (
      .clock           (clock),
      .ctl             (ctl),
      .sts             (sts),
      .req_opcode      (req_opcode),
      .req_day         (req_day),
      .req_month       (req_month),
      .req_year        (req_year),
      .req_other_day   (req_other_day),
      .req_other_month (req_other_month),
      .req_other_year  (req_other_year),
      .req_add_count   (req_add_count),
      .year_rem        (year_rem),
      .rsp_out_day     (rsp_out_day),
      .rsp_out_month   (rsp_out_month),
      .rsp_out_year    (rsp_out_year),
      .rsp_day_of_year (rsp_day_of_year),
      .rsp_is_less     (rsp_is_less),
      .rsp_is_equal    (rsp_is_equal)
   );

`ifndef SYNTH
   // A result beat lasts exactly one cycle.
   assert property (@(posedge clock) disable iff (reset) rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one cycle");

   // An accepted beat makes the block busy on the next cycle.
   assert property (@(posedge clock) disable iff (reset) (start && !busy) |=> busy)
      else $error("accepted beat did not raise busy");

   // The block only goes idle right after delivering a result.
   assert property (@(posedge clock) disable iff (reset) $fell(busy) |-> $past(rsp_valid))
      else $error("busy dropped without a result beat");
`endif

endmodule

// ===== design/gda_rem400.sv =====
// Reduction of the year modulo 400 by a reciprocal multiply, in a multiply phase and a subtract phase.
module gda_rem400 import gda_pkg::*; #(
   parameter int YEAR_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  logic [YEAR_BITS-1:0] year,
   output logic                 done,
   output logic [8:0]           rem
);

   // With SHIFT = YEAR_BITS + 9 the rounded-up reciprocal gives an exact quotient
   // for every year that fits in YEAR_BITS.
   localparam int SHIFT = YEAR_BITS + 9;
   localparam int RW    = YEAR_BITS + 1;
   localparam int PW    = YEAR_BITS + RW;
   localparam int QW    = PW - SHIFT;
   localparam logic [63:0] RECIP_WIDE =
      ((64'd1 << SHIFT) + 64'(LEAP_SPAN - 1)) / 64'(LEAP_SPAN);
   localparam logic [RW-1:0] RECIP = RW'(RECIP_WIDE);

   localparam logic [1:0] PH_DONE = 2'd0;
   localparam logic [1:0] PH_MUL  = 2'd1;
   localparam logic [1:0] PH_SUB  = 2'd2;

   logic [YEAR_BITS-1:0] year_ff, year_in;
   logic [QW-1:0]        quot_ff, quot_in;
   logic [8:0]           rem_ff, rem_in;
   logic [1:0]           phase_ff, phase_in;
   logic [PW-1:0]        prod;
   logic [YEAR_BITS-1:0] span_total;

   assign prod       = PW'(year_ff) * PW'(RECIP);
   assign span_total = YEAR_BITS'(quot_ff) * YEAR_BITS'(LEAP_SPAN);

   always_comb begin
      year_in  = year_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      phase_in = phase_ff;
      if (load) begin
         year_in  = year;
         phase_in = PH_MUL;
      end else begin
         unique case (phase_ff)
            PH_MUL: begin
               quot_in  = QW'(prod >> SHIFT);
               phase_in = PH_SUB;
            end
            PH_SUB: begin
               rem_in   = 9'(year_ff - span_total);
               phase_in = PH_DONE;
            end
            default: begin
               phase_in = PH_DONE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      year_ff <= year_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      if (reset) begin
         phase_ff <= PH_DONE;
      end else begin
         phase_ff <= phase_in;
      end
   end

   assign done = (phase_ff == PH_DONE);
   assign rem  = rem_ff;

endmodule

// ===== design/gda_datapath.sv =====
// Date registers and the shared add/subtract unit that walks months and sums days.
module gda_datapath import gda_pkg::*; #(
   parameter int YEAR_BITS  = 16,
   parameter int COUNT_BITS = 16
) (
   input  logic                  clock,
   input  gda_ctl_type           ctl,
   output gda_sts_type           sts,
   input  logic [1:0]            req_opcode,
   input  logic [4:0]            req_day,
   input  logic [3:0]            req_month,
   input  logic [YEAR_BITS-1:0]  req_year,
   input  logic [4:0]            req_other_day,
   input  logic [3:0]            req_other_month,
   input  logic [YEAR_BITS-1:0]  req_other_year,
   input  logic [COUNT_BITS-1:0] req_add_count,
   input  logic [8:0]            year_rem,
   output logic [4:0]            rsp_out_day,
   output logic [3:0]            rsp_out_month,
   output logic [YEAR_BITS-1:0]  rsp_out_year,
   output logic [8:0]            rsp_day_of_year,
   output logic                  rsp_is_less,
   output logic                  rsp_is_equal
);

   localparam int DW    = COUNT_BITS + 1;
   localparam int CMP_W = (DW > 18) ? DW : 18;

   logic [1:0]           op_ff, op_in;
   logic [DW-1:0]        d_ff, d_in;
   logic [3:0]           m_ff, m_in;
   logic [YEAR_BITS-1:0] y_ff, y_in;
   logic [8:0]           r_ff, r_in;
   logic [4:0]           od_ff, od_in;
   logic [3:0]           om_ff, om_in;
   logic [YEAR_BITS-1:0] oy_ff, oy_in;
   logic [8:0]           doy_ff, doy_in;
   logic [3:0]           idx_ff, idx_in;
   logic                 less_ff, less_in;
   logic                 eq_ff, eq_in;

   logic [3:0]           sel_month;
   logic [4:0]           mlen;
   logic                 over;
   logic                 skip;
   logic [DW-1:0]        add_a, add_b, add_y, load_inc;
   logic [YEAR_BITS-1:0] y_next;
   logic [8:0]           r_next;

   assign sel_month = (op_ff == OP_DOY) ? idx_ff : m_ff;
   assign mlen      = month_len(sel_month, is_leap(r_ff));
   assign over      = d_ff > DW'(mlen);

   // A whole 400-year span is skipped only while the year cannot wrap.
   assign skip = (m_ff >= 4'd1) && (m_ff <= 4'd12)
              && (CMP_W'(d_ff) > CMP_W'(CYCLE_DAYS))
              && (({1'b0, y_ff} + (YEAR_BITS+1)'(CYCLE_YEARS)) < {1'b0, {YEAR_BITS{1'b1}}});

   // Shared unit: adding days subtracts a month length or 400-year span; summing adds.
   assign add_a = (op_ff == OP_DOY) ? DW'(doy_ff) : d_ff;
   assign add_b = skip ? DW'(CYCLE_DAYS) : DW'(mlen);
   assign add_y = (op_ff == OP_DOY) ? add_a + add_b : add_a - add_b;

   assign y_next = y_ff + YEAR_BITS'(1);
   assign r_next = ((&y_ff) || (r_ff == 9'(LEAP_SPAN - 1))) ? 9'd0 : r_ff + 9'd1;

   always_comb begin
      unique case (req_opcode)
         OP_ADD:  load_inc = DW'(req_add_count);
         OP_NEXT: load_inc = DW'(1);
         default: load_inc = '0;
      endcase
   end

   always_comb begin
      unique case (op_ff)
         OP_ADD:  sts.exec_done = !over;
         OP_DOY:  sts.exec_done = !(idx_ff < m_ff);
         default: sts.exec_done = 1'b1;
      endcase
   end

   always_comb begin
      op_in   = op_ff;
      d_in    = d_ff;
      m_in    = m_ff;
      y_in    = y_ff;
      r_in    = r_ff;
      od_in   = od_ff;
      om_in   = om_ff;
      oy_in   = oy_ff;
      doy_in  = doy_ff;
      idx_in  = idx_ff;
      less_in = less_ff;
      eq_in   = eq_ff;
      if (ctl.load) begin
         op_in   = req_opcode;
         d_in    = DW'(req_day) + load_inc;
         m_in    = req_month;
         y_in    = req_year;
         od_in   = req_other_day;
         om_in   = req_other_month;
         oy_in   = req_other_year;
         doy_in  = 9'(req_day);
         idx_in  = 4'd1;
         less_in = 1'b0;
         eq_in   = 1'b0;
      end else if (ctl.load_r) begin
         r_in = year_rem;
      end else if (ctl.step) begin
         unique case (op_ff)
            OP_NEXT, OP_ADD: begin
               if (over) begin
                  d_in = (op_ff == OP_NEXT) ? DW'(1) : add_y;
                  if (skip && op_ff == OP_ADD) begin
                     y_in = y_ff + YEAR_BITS'(CYCLE_YEARS);
                  end else if (m_ff >= 4'd12) begin
                     m_in = 4'd1;
                     y_in = y_next;
                     r_in = r_next;
                  end else begin
                     m_in = m_ff + 4'd1;
                  end
               end
            end
            OP_DOY: begin
               if (idx_ff < m_ff) begin
                  doy_in = add_y[8:0];
                  idx_in = idx_ff + 4'd1;
               end
            end
            OP_CMP: begin
               less_in = (y_ff < oy_ff)
                      || (y_ff == oy_ff && m_ff < om_ff)
                      || (y_ff == oy_ff && m_ff == om_ff && d_ff[4:0] < od_ff);
               eq_in   = (y_ff == oy_ff) && (m_ff == om_ff) && (d_ff[4:0] == od_ff);
            end
            default: begin
               d_in = d_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      d_ff    <= d_in;
      m_ff    <= m_in;
      y_ff    <= y_in;
      r_ff    <= r_in;
      od_ff   <= od_in;
      om_ff   <= om_in;
      oy_ff   <= oy_in;
      doy_ff  <= doy_in;
      idx_ff  <= idx_in;
      less_ff <= less_in;
      eq_ff   <= eq_in;
   end

   assign rsp_out_day     = d_ff[4:0];
   assign rsp_out_month   = m_ff;
   assign rsp_out_year    = y_ff;
   assign rsp_day_of_year = (op_ff == OP_DOY) ? doy_ff : 9'd0;
   assign rsp_is_less     = less_ff;
   assign rsp_is_equal    = eq_ff;

endmodule
